### design/lkv_pkg.sv
// Shared types and constants for the LRU key/value cache.
package lkv_pkg;

    localparam int KEY_W           = 16;
    localparam int VAL_W           = 20;
    localparam int CAP_W           = 5;
    localparam int ENTRIES_DEFAULT = 16;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic {
        MODE_GET = 1'b0,
        MODE_PUT = 1'b1
    } mode_t;

    // One request presented to the store for execution this cycle.
    typedef struct packed {
        logic             go;
        mode_t            mode;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } lkv_req_t;

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] read_value;
    } lkv_rsp_t;

endpackage

### design/lkv_match.sv
// Parallel key compare across all entries of the cache.
module lkv_match #(
    parameter int ENTRIES = lkv_pkg::ENTRIES_DEFAULT
) (
    input  logic [lkv_pkg::KEY_W-1:0] key,
    input  logic [lkv_pkg::KEY_W-1:0] keys [ENTRIES],
    input  logic [ENTRIES-1:0]        valid,
    output logic [ENTRIES-1:0]        match
);

    // Keys are unique among valid entries, so at most one bit is set.
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            match[i] = valid[i] && (keys[i] == key);
        end
    end

endmodule

### design/lkv_store.sv
// Entry storage, recency ranks and update logic for the cache.
module lkv_store #(
    parameter int ENTRIES = lkv_pkg::ENTRIES_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  lkv_pkg::lkv_req_t         req,
    input  logic [lkv_pkg::CAP_W-1:0] capacity,
    output lkv_pkg::lkv_rsp_t         rsp,
    output logic [$clog2(ENTRIES+1)-1:0] occ_count,
    output logic [ENTRIES-1:0]        occ_valid
);

    localparam int RANK_W = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int CMP_W  = (CNT_W > lkv_pkg::CAP_W) ? CNT_W : lkv_pkg::CAP_W;

    logic [lkv_pkg::KEY_W-1:0] keys_reg   [ENTRIES];
    logic [lkv_pkg::VAL_W-1:0] values_reg [ENTRIES];
    logic [ENTRIES-1:0]        valid_reg;
    logic [ENTRIES-1:0]        valid_next;
    logic [RANK_W-1:0]         rank_reg   [ENTRIES];
    logic [RANK_W-1:0]         rank_next  [ENTRIES];
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;

    logic [ENTRIES-1:0]        match;
    logic                      hit_any;
    logic [lkv_pkg::VAL_W-1:0] hit_value;
    logic [RANK_W-1:0]         hit_rank;
    logic [CMP_W-1:0]          cap_eff;
    logic [CNT_W-1:0]          count_m1;
    logic                      put_miss;
    logic                      evict_en;
    logic [ENTRIES-1:0]        victim;
    logic [ENTRIES-1:0]        valid_kept;
    logic [ENTRIES-1:0]        slot_oh;
    logic [ENTRIES-1:0]        key_we;
    logic [ENTRIES-1:0]        val_we;

    lkv_match #(
        .ENTRIES (ENTRIES)
    ) u_match (
        .key   (req.key),
        .keys  (keys_reg),
        .valid (valid_reg),
        .match (match)
    );

    // Clamp capacity to 1..ENTRIES.
    always_comb
    begin
        cap_eff = CMP_W'(capacity);
        if (capacity == '0)
        begin
            cap_eff = CMP_W'(1);
        end
        else if (cap_eff > CMP_W'(ENTRIES))
        begin
            cap_eff = CMP_W'(ENTRIES);
        end
    end

    always_comb
    begin
        hit_value = '0;
        hit_rank  = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (match[i])
            begin
                hit_value = hit_value | values_reg[i];
                hit_rank  = hit_rank | rank_reg[i];
            end
        end
    end

    assign hit_any  = |match;
    assign count_m1 = count_reg - CNT_W'(1);
    assign put_miss = (req.mode == lkv_pkg::MODE_PUT) && !hit_any;
    assign evict_en = put_miss && (CMP_W'(count_reg) >= cap_eff);

    // Ranks of valid entries form 0..count-1, so the oldest holds count-1.
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            victim[i] = evict_en && valid_reg[i] &&
                        (rank_reg[i] == count_m1[RANK_W-1:0]);
        end
    end

    assign valid_kept = valid_reg & ~victim;
    // Lowest free slot after eviction.
    assign slot_oh    = ~valid_kept & (valid_kept + ENTRIES'(1));

    always_comb
    begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        count_next = count_reg;
        key_we     = '0;
        val_we     = '0;
        if (req.go)
        begin
            if (hit_any)
            begin
                // Promote the hit; younger entries age by one.
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (match[i])
                    begin
                        rank_next[i] = '0;
                    end
                    else if (valid_reg[i] && (rank_reg[i] < hit_rank))
                    begin
                        rank_next[i] = rank_reg[i] + RANK_W'(1);
                    end
                end
                if (req.mode == lkv_pkg::MODE_PUT)
                begin
                    val_we = match;
                end
            end
            else if (put_miss)
            begin
                valid_next = valid_kept | slot_oh;
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (slot_oh[i])
                    begin
                        rank_next[i] = '0;
                    end
                    else if (valid_kept[i])
                    begin
                        rank_next[i] = rank_reg[i] + RANK_W'(1);
                    end
                end
                key_we     = slot_oh;
                val_we     = slot_oh;
                count_next = count_reg - CNT_W'(evict_en) + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
            rank_reg  <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (key_we[i])
            begin
                keys_reg[i] <= req.key;
            end
            if (val_we[i])
            begin
                values_reg[i] <= req.value;
            end
        end
    end

    assign rsp.hit        = hit_any;
    assign rsp.read_value = (req.mode == lkv_pkg::MODE_GET && hit_any) ? hit_value : '0;
    assign occ_count      = count_reg;
    assign occ_valid      = valid_reg;

endmodule

### design/lru_key_value_cache.sv
// Top level of the fully associative LRU key/value cache.
//
//   Channel  Handshake              Payload
//   -------  ---------------------  -------------------------
//   in       in_valid / in_stall    mode, key, value
//   out      out_valid / out_stall  hit, read_value
//   cfg      cfg_wr_en              cfg_wr_data (capacity)
//
// One request per cycle while the output is not stalled. A request is held in
// the input register, is looked up and applied to the entry store by the
// parallel key compare, and its result lands in the output register, where
// out_valid marks it.
// Reset empties the cache and sets capacity to 16. A stalled output holds
// the pending request in the input register and stalls the input.
module lru_key_value_cache #(
    parameter int ENTRIES = lkv_pkg::ENTRIES_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      mode,
    input  logic [lkv_pkg::KEY_W-1:0] key,
    input  logic [lkv_pkg::VAL_W-1:0] value,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      hit,
    output logic [lkv_pkg::VAL_W-1:0] read_value,
    input  logic                      cfg_wr_en,
    input  logic [lkv_pkg::CAP_W-1:0] cfg_wr_data
);

    localparam int CNT_W = $clog2(ENTRIES + 1);

    logic                      req_valid_reg;
    logic                      req_valid_next;
    logic                      req_mode_reg;
    logic [lkv_pkg::KEY_W-1:0] req_key_reg;
    logic [lkv_pkg::VAL_W-1:0] req_value_reg;
    logic [lkv_pkg::CAP_W-1:0] capacity_reg;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic                      hit_reg;
    logic [lkv_pkg::VAL_W-1:0] read_value_reg;
    logic                      advance;
    logic                      accept;
    lkv_pkg::lkv_req_t         req;
    lkv_pkg::lkv_rsp_t         rsp;
    logic [CNT_W-1:0]          occ_count;
    logic [ENTRIES-1:0]        occ_valid;

    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = req_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    assign req.go    = req_valid_reg && advance;
    assign req.mode  = lkv_pkg::mode_t'(req_mode_reg);
    assign req.key   = req_key_reg;
    assign req.value = req_value_reg;

    lkv_store #(
        .ENTRIES (ENTRIES)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .capacity  (capacity_reg),
        .rsp       (rsp),
        .occ_count (occ_count),
        .occ_valid (occ_valid)
    );

    always_comb
    begin
        req_valid_next = req_valid_reg;
        if (accept)
        begin
            req_valid_next = 1'b1;
        end
        else if (advance)
        begin
            req_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = req_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            capacity_reg  <= lkv_pkg::CAP_RESET;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                capacity_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_mode_reg  <= mode;
            req_key_reg   <= key;
            req_value_reg <= value;
        end
        if (req.go)
        begin
            hit_reg        <= rsp.hit;
            read_value_reg <= rsp.read_value;
        end
    end

    assign out_valid  = out_valid_reg;
    assign hit        = hit_reg;
    assign read_value = read_value_reg;

    // A request applied to the store must produce a result next cycle.
    a_go_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        req.go |=> out_valid)
        else $error("request executed without a result");

    // Occupied count tracks the number of valid entries.
    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(occ_valid) == int'(occ_count))
        else $error("occupied count out of step with valid entries");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        int'(occ_count) <= ENTRIES)
        else $error("occupied count above entry count");

    // Only an inserting put grows the cache, by one entry; here the count must hold without a request.
    a_count_growth: assert property (@(posedge clk) disable iff (!rst_n)
        !req.go |=> $stable(occ_count))
        else $error("occupied count changed without a request");

endmodule

### bench/lru_key_value_cache_test.sv
// Self-checking testbench for the LRU key/value cache, with a shadow model as scoreboard.
`timescale 1ns / 1ps

class cache_shadow;
    logic [lkv_pkg::KEY_W-1:0] slot_key [lkv_pkg::ENTRIES_DEFAULT];
    logic [lkv_pkg::VAL_W-1:0] slot_val [lkv_pkg::ENTRIES_DEFAULT];
    bit                        slot_used [lkv_pkg::ENTRIES_DEFAULT];
    int unsigned               slot_age [lkv_pkg::ENTRIES_DEFAULT];
    int unsigned               fill;
    logic [lkv_pkg::CAP_W-1:0] capacity;
    lkv_pkg::lkv_rsp_t         due_rsp [$];
    int                        mismatches;

    function new();
        foreach (slot_used[i])
        begin
            slot_used[i] = 1'b0;
            slot_age[i]  = 0;
        end
        fill       = 0;
        capacity   = lkv_pkg::CAP_RESET;
        mismatches = 0;
    endfunction

    function void set_capacity(logic [lkv_pkg::CAP_W-1:0] c);
        capacity = c;
    endfunction

    function int outstanding();
        return due_rsp.size();
    endfunction

    // Zero acts as one, anything past the store depth saturates.
    function int unsigned usable_slots();
        int unsigned c;
        c = 32'(capacity);
        if (c == 0)
            c = 1;
        if (c > lkv_pkg::ENTRIES_DEFAULT)
            c = lkv_pkg::ENTRIES_DEFAULT;
        return c;
    endfunction

    function void make_recent(int s);
        int unsigned r;
        r = slot_age[s];
        foreach (slot_used[i])
            if (slot_used[i] && slot_age[i] < r)
                slot_age[i]++;
        slot_age[s] = 0;
    endfunction

    function void drop_oldest();
        int victim;
        int unsigned oldest;
        victim = -1;
        oldest = 0;
        foreach (slot_used[i])
            if (slot_used[i] && (victim < 0 || slot_age[i] >= oldest))
            begin
                victim = i;
                oldest = slot_age[i];
            end
        if (victim >= 0)
        begin
            slot_used[victim] = 1'b0;
            slot_age[victim]  = 0;
            if (fill > 0)
                fill--;
        end
    endfunction

    function int free_slot();
        foreach (slot_used[i])
            if (!slot_used[i])
                return i;
        return -1;
    endfunction

    function void add_entry(logic [lkv_pkg::KEY_W-1:0] k, logic [lkv_pkg::VAL_W-1:0] v);
        int s;
        if (fill >= usable_slots())
            drop_oldest();
        s = free_slot();
        if (s < 0)
        begin
            drop_oldest();
            s = free_slot();
            if (s < 0)
                return;
        end
        foreach (slot_used[i])
            if (slot_used[i])
                slot_age[i]++;
        slot_key[s]  = k;
        slot_val[s]  = v;
        slot_used[s] = 1'b1;
        slot_age[s]  = 0;
        fill++;
    endfunction

    function void take_request(lkv_pkg::mode_t m, logic [lkv_pkg::KEY_W-1:0] k,
                               logic [lkv_pkg::VAL_W-1:0] v);
        int found;
        lkv_pkg::lkv_rsp_t r;
        found = -1;
        foreach (slot_used[i])
            if (found < 0 && slot_used[i] && slot_key[i] == k)
                found = i;
        r.hit        = (found >= 0);
        r.read_value = '0;
        if (m == lkv_pkg::MODE_GET)
        begin
            if (found >= 0)
            begin
                r.read_value = slot_val[found];
                make_recent(found);
            end
        end
        else if (found >= 0)
        begin
            slot_val[found] = v;
            make_recent(found);
        end
        else
            add_entry(k, v);
        due_rsp.push_back(r);
    endfunction

    function void match_response(logic h, logic [lkv_pkg::VAL_W-1:0] rv);
        lkv_pkg::lkv_rsp_t want;
        if (due_rsp.size() == 0)
        begin
            $display("%0t: unexpected result, hit %0b read_value %05h", $time, h, rv);
            mismatches++;
            return;
        end
        want = due_rsp.pop_front();
        if (h !== want.hit)
        begin
            $display("%0t: hit expected %0b, actual %0b", $time, want.hit, h);
            mismatches++;
        end
        if (rv !== want.read_value)
        begin
            $display("%0t: read_value expected %05h, actual %05h",
                     $time, want.read_value, rv);
            mismatches++;
        end
    endfunction
endclass

module lru_key_value_cache_test;
    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic                      mode;
    logic [lkv_pkg::KEY_W-1:0] key;
    logic [lkv_pkg::VAL_W-1:0] value;
    logic                      out_valid;
    logic                      out_stall;
    logic                      hit;
    logic [lkv_pkg::VAL_W-1:0] read_value;
    logic                      cfg_wr_en;
    logic [lkv_pkg::CAP_W-1:0] cfg_wr_data;

    cache_shadow               shadow;
    int                        gap_pct;
    int                        stall_pct;
    logic [lkv_pkg::KEY_W-1:0] key_pool [32];
    int                        pool_size;

    lru_key_value_cache dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .key         (key),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .hit         (hit),
        .read_value  (read_value),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("lru_key_value_cache regression: fail");
        $finish;
    end

    // Result side: stall in random bursts.
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 99) < stall_pct)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                shadow.match_response(hit, read_value);
        end
    end

    // Present one request, optionally after an idle burst, and hold it until taken.
    task automatic issue_request(lkv_pkg::mode_t m, logic [lkv_pkg::KEY_W-1:0] k,
                                 logic [lkv_pkg::VAL_W-1:0] v);
        if ($urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        key      <= k;
        value    <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        shadow.take_request(m, k, v);
    endtask

    // Drain the pipeline before touching the register.
    task automatic write_capacity(logic [lkv_pkg::CAP_W-1:0] c);
        in_valid <= 1'b0;
        while (shadow.outstanding() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= c;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        shadow.set_capacity(c);
    endtask

    task automatic directed_requests();
        issue_request(lkv_pkg::MODE_GET, 16'h0000, 20'h12345);
        issue_request(lkv_pkg::MODE_PUT, 16'h0000, 20'h00000);
        issue_request(lkv_pkg::MODE_PUT, 16'hFFFF, 20'hFFFFF);
        issue_request(lkv_pkg::MODE_GET, 16'hFFFF, 20'h00000);
        issue_request(lkv_pkg::MODE_GET, 16'h0000, 20'hFFFFF);
        issue_request(lkv_pkg::MODE_PUT, 16'h0000, 20'hABCDE);
        issue_request(lkv_pkg::MODE_GET, 16'h0000, 20'h00000);
        issue_request(lkv_pkg::MODE_GET, 16'h1234, 20'h00000);
        // fill the store to its depth, then one more to force an eviction
        for (int i = 1; i <= 14; i++)
            issue_request(lkv_pkg::MODE_PUT, 16'(16'h0101 * i), 20'(i * 20'h0F0F1));
        issue_request(lkv_pkg::MODE_PUT, 16'h5555, 20'h55555);
        issue_request(lkv_pkg::MODE_GET, 16'h0000, 20'h00000);
        // shrink below the fill: each insert still evicts only one
        write_capacity(5'd2);
        issue_request(lkv_pkg::MODE_PUT, 16'h6666, 20'h66666);
        issue_request(lkv_pkg::MODE_GET, 16'hFFFF, 20'h00000);
    endtask

    task automatic random_phase(logic [lkv_pkg::CAP_W-1:0] c, int count);
        int unsigned lim;
        logic [lkv_pkg::KEY_W-1:0] k;
        logic [lkv_pkg::VAL_W-1:0] v;
        lkv_pkg::mode_t m;
        write_capacity(c);
        lim = shadow.usable_slots();
        pool_size = int'(lim) + int'($urandom_range(1, 6));
        for (int i = 0; i < pool_size; i++)
            key_pool[i] = lkv_pkg::KEY_W'($urandom);
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 99) < 10)
                k = lkv_pkg::KEY_W'($urandom);
            else
                k = key_pool[$urandom_range(0, pool_size - 1)];
            case ($urandom_range(0, 19))
                0, 1:    v = '1;
                2:       v = '0;
                default: v = lkv_pkg::VAL_W'($urandom);
            endcase
            m = ($urandom_range(0, 1) == 1) ? lkv_pkg::MODE_PUT : lkv_pkg::MODE_GET;
            issue_request(m, k, v);
        end
    endtask

    initial
    begin
        logic [lkv_pkg::CAP_W-1:0] caps [10];
        caps = '{5'd1, 5'd0, 5'd31, 5'd16, 5'd3, 5'd17, 5'd8, 5'd2, 5'd12, 5'd16};
        shadow      = new();
        gap_pct     = 15;
        stall_pct   = 10;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        mode        <= lkv_pkg::MODE_GET;
        key         <= '0;
        value       <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_requests();

        for (int p = 0; p < 10; p++)
        begin
            if (p == 9)
            begin
                // run the last stretch flat out
                gap_pct   = 0;
                stall_pct = 0;
            end
            else
            begin
                gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(5, 30));
                stall_pct = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(5, 30));
            end
            random_phase(caps[p], 190);
        end

        in_valid <= 1'b0;
        while (shadow.outstanding() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (shadow.mismatches == 0)
            $display("lru_key_value_cache regression: pass");
        else
            $display("lru_key_value_cache regression: fail");
        $finish;
    end
endmodule

### sim.f
design/lkv_pkg.sv
design/lkv_match.sv
design/lkv_store.sv
design/lru_key_value_cache.sv
bench/lru_key_value_cache_test.sv
